[rtl/core/sqg_pkg.sv]
// ----------------------------------------------------------------------------
// sqg_pkg
// Shared types, constants and rounding for the single-qubit gate unit.
// ----------------------------------------------------------------------------
package sqg_pkg;

  localparam int AMP_WIDTH   = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int FRAC_BITS   = 14;

  // Intermediate amplitudes stay unclipped between gate stages.
  localparam int WIDE_W = AMP_WIDTH + 3;
  localparam int COEF_W = 16;
  localparam int PROD_W = WIDE_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;

  typedef logic signed [AMP_WIDTH-1:0] amp_t;
  typedef logic signed [WIDE_W-1:0]    wamp_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  typedef enum logic [1:0] {
    MODE_HAD   = 2'd0,
    MODE_PHASE = 2'd1,
    MODE_ROT   = 2'd2,
    MODE_SEQ   = 2'd3
  } gate_mode_t;

  localparam coef_t ONE_Q14     = 16'sd16384;
  localparam coef_t ZERO_Q14    = 16'sd0;
  localparam coef_t INV_SQRT2   = 16'sd11585;
  localparam coef_t COS_PI4     = 16'sd11585;
  localparam coef_t SIN_PI4     = 16'sd11585;
  localparam coef_t COS_PI6     = 16'sd14189;
  localparam coef_t SIN_PI6     = 16'sd8192;
  localparam int    HALF_LSB    = 1 << (FRAC_BITS - 1);

  localparam wamp_t AMP_MAX = WIDE_W'((1 <<< (AMP_WIDTH - 1)) - 1);
  localparam wamp_t AMP_MIN = WIDE_W'(-(1 <<< (AMP_WIDTH - 1)));

  typedef struct packed {
    wamp_t a0_re;
    wamp_t a0_im;
    wamp_t a1_re;
    wamp_t a1_im;
  } amp_set_t;

  // n0 = k00*a0 + k01*a1, n1 = k10*a0 + k11*a1, on real and imaginary parts
  typedef struct packed {
    coef_t k00;
    coef_t k01;
    coef_t k10;
    coef_t k11;
  } mix_coef_t;

  typedef struct packed {
    coef_t c;
    coef_t s;
  } trig_t;

  typedef struct packed {
    amp_t out0_re;
    amp_t out0_im;
    amp_t out1_re;
    amp_t out1_im;
    logic saturated;
  } out_item_t;

  // Round a Q14-scaled sum to nearest, ties toward plus infinity.
  function automatic wamp_t round_q14(input sum_t v);
    sum_t w;
    w = v + sum_t'(HALF_LSB);
    return WIDE_W'(w >>> FRAC_BITS);
  endfunction

endpackage

[rtl/core/sqg_in_if.sv]
// ----------------------------------------------------------------------------
// sqg_in_if
// Input channel: gate selector, angle and the two complex amplitudes.
// ----------------------------------------------------------------------------
interface sqg_in_if import sqg_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [ANGLE_WIDTH-1:0] angle;
  amp_t                   amp0_re;
  amp_t                   amp0_im;
  amp_t                   amp1_re;
  amp_t                   amp1_im;

  modport source (
    output valid, mode, angle, amp0_re, amp0_im, amp1_re, amp1_im,
    input  ready
  );

  modport sink (
    input  valid, mode, angle, amp0_re, amp0_im, amp1_re, amp1_im,
    output ready
  );

endinterface

[rtl/core/sqg_out_if.sv]
// ----------------------------------------------------------------------------
// sqg_out_if
// Result channel: the new amplitudes and the clip flag.
// ----------------------------------------------------------------------------
interface sqg_out_if import sqg_pkg::*; ();

  logic valid;
  logic ready;
  amp_t out0_re;
  amp_t out0_im;
  amp_t out1_re;
  amp_t out1_im;
  logic saturated;

  modport source (
    output valid, out0_re, out0_im, out1_re, out1_im, saturated,
    input  ready
  );

  modport sink (
    input  valid, out0_re, out0_im, out1_re, out1_im, saturated,
    output ready
  );

endinterface

[rtl/core/sqg_trig.sv]
// ----------------------------------------------------------------------------
// sqg_trig
// Seven-stage sine/cosine pipeline: Horner polynomials on the reduced angle,
// one multiply per stage, then Q14 rounding and quadrant mapping.
// ----------------------------------------------------------------------------
module sqg_trig import sqg_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output trig_t                  cs
);

  localparam int TB = ANGLE_WIDTH - 2;

  localparam logic [30:0] SIN_K1  = 31'd1686629713;
  localparam logic [30:0] SIN_K3  = 31'd693598669;
  localparam logic [30:0] SIN_K5  = 31'd85569306;
  localparam logic [30:0] SIN_K7  = 31'd5026992;
  localparam logic [30:0] SIN_K9  = 31'd172273;
  localparam logic [30:0] COS_K2  = 31'd1324675880;
  localparam logic [30:0] COS_K4  = 31'd272375560;
  localparam logic [30:0] COS_K6  = 31'd22401990;
  localparam logic [30:0] COS_K8  = 31'd987047;
  localparam logic [30:0] COS_K10 = 31'd27061;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  function automatic logic [30:0] mul_q30(input logic [29:0] u, input logic [30:0] p);
    logic [60:0] m;
    m = {31'd0, u} * {30'd0, p};
    return m[60:30];
  endfunction

  function automatic logic [14:0] to_q14(input logic [30:0] v);
    logic [31:0] r;
    r = ({1'b0, v} + 32'h0000_8000) >> 16;
    if (r[15:0] > 16'd16384) begin
      return 15'd16384;
    end
    return r[14:0];
  endfunction

  logic [29:0] t_in;
  logic [59:0] tt;

  logic [29:0] t_r   [1:5];
  logic [29:0] u_r   [1:5];
  quad_t       q_r   [1:6];
  logic [30:0] ps_r  [2:5];
  logic [30:0] pc_r  [2:5];
  logic [30:0] sv_r;
  logic [30:0] dec_r;
  trig_t       cs_r;

  logic [30:0] cv;
  logic [14:0] s0;
  logic [14:0] c0;
  coef_t       cz;
  coef_t       sz;
  trig_t       cs_nxt;

  assign t_in = {angle[TB-1:0], {(32 - ANGLE_WIDTH){1'b0}}};
  assign tt   = {30'd0, t_in} * {30'd0, t_in};

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[1]  <= t_in;
      u_r[1]  <= tt[59:30];
      q_r[1]  <= quad_t'(angle[ANGLE_WIDTH-1 -: 2]);
      for (int k = 2; k <= 5; k++) begin
        t_r[k] <= t_r[k-1];
        u_r[k] <= u_r[k-1];
      end
      for (int k = 2; k <= 6; k++) begin
        q_r[k] <= q_r[k-1];
      end
      ps_r[2] <= SIN_K7 - mul_q30(u_r[1], SIN_K9);
      pc_r[2] <= COS_K8 - mul_q30(u_r[1], COS_K10);
      ps_r[3] <= SIN_K5 - mul_q30(u_r[2], ps_r[2]);
      pc_r[3] <= COS_K6 - mul_q30(u_r[2], pc_r[2]);
      ps_r[4] <= SIN_K3 - mul_q30(u_r[3], ps_r[3]);
      pc_r[4] <= COS_K4 - mul_q30(u_r[3], pc_r[3]);
      ps_r[5] <= SIN_K1 - mul_q30(u_r[4], ps_r[4]);
      pc_r[5] <= COS_K2 - mul_q30(u_r[4], pc_r[4]);
      sv_r    <= mul_q30(t_r[5], ps_r[5]);
      dec_r   <= mul_q30(u_r[5], pc_r[5]);
      cs_r    <= cs_nxt;
    end
  end

  always_comb begin
    cv = (dec_r >= ONE_Q30) ? '0 : ONE_Q30 - dec_r;
    s0 = to_q14(sv_r);
    c0 = to_q14(cv);
    cz = coef_t'({1'b0, c0});
    sz = coef_t'({1'b0, s0});
    unique case (q_r[6])
      QUAD_0: cs_nxt = '{c: cz,  s: sz};
      QUAD_1: cs_nxt = '{c: -sz, s: cz};
      QUAD_2: cs_nxt = '{c: -cz, s: -sz};
      QUAD_3: cs_nxt = '{c: sz,  s: -cz};
      default: cs_nxt = '{c: cz, s: sz};
    endcase
  end

  assign cs = cs_r;

endmodule

[rtl/core/sqg_mix.sv]
// ----------------------------------------------------------------------------
// sqg_mix
// Two-stage real 2x2 matrix applied to both parts of the two amplitudes:
// eight products, then pairwise sums rounded to Q14.
// ----------------------------------------------------------------------------
module sqg_mix import sqg_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  amp_set_t  a,
  input  mix_coef_t k,
  output amp_set_t  y
);

  prod_t    p_r [8];
  amp_set_t y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= a.a0_re * k.k00;
      p_r[1] <= a.a1_re * k.k01;
      p_r[2] <= a.a0_im * k.k00;
      p_r[3] <= a.a1_im * k.k01;
      p_r[4] <= a.a0_re * k.k10;
      p_r[5] <= a.a1_re * k.k11;
      p_r[6] <= a.a0_im * k.k10;
      p_r[7] <= a.a1_im * k.k11;
      y_r.a0_re <= round_q14(sum_t'(p_r[0]) + sum_t'(p_r[1]));
      y_r.a0_im <= round_q14(sum_t'(p_r[2]) + sum_t'(p_r[3]));
      y_r.a1_re <= round_q14(sum_t'(p_r[4]) + sum_t'(p_r[5]));
      y_r.a1_im <= round_q14(sum_t'(p_r[6]) + sum_t'(p_r[7]));
    end
  end

  assign y = y_r;

endmodule

[rtl/core/sqg_phase.sv]
// ----------------------------------------------------------------------------
// sqg_phase
// Two-stage complex multiply of the |1> amplitude by (c + i*s);
// the |0> amplitude rides along unchanged.
// ----------------------------------------------------------------------------
module sqg_phase import sqg_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  amp_set_t a,
  input  trig_t    cs,
  output amp_set_t y
);

  prod_t    p_r [4];
  wamp_t    a0_re_r;
  wamp_t    a0_im_r;
  amp_set_t y_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]    <= a.a1_re * cs.c;
      p_r[1]    <= a.a1_im * cs.s;
      p_r[2]    <= a.a1_re * cs.s;
      p_r[3]    <= a.a1_im * cs.c;
      a0_re_r   <= a.a0_re;
      a0_im_r   <= a.a0_im;
      y_r.a0_re <= a0_re_r;
      y_r.a0_im <= a0_im_r;
      y_r.a1_re <= round_q14(sum_t'(p_r[0]) - sum_t'(p_r[1]));
      y_r.a1_im <= round_q14(sum_t'(p_r[2]) + sum_t'(p_r[3]));
    end
  end

  assign y = y_r;

endmodule

[rtl/core/sqg_outq.sv]
// ----------------------------------------------------------------------------
// sqg_outq
// Two-entry output queue between the gate pipeline and the result channel.
// ----------------------------------------------------------------------------
module sqg_outq import sqg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  out_item_t  push_data,
  output logic       full,
  sqg_out_if.source  out_chan
);

  out_item_t h0_r;
  out_item_t h1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      unique case ({push, pop})
        2'b10: cnt_r <= cnt_r + 2'd1;
        2'b01: cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          h0_r <= push_data;
        end else begin
          h1_r <= push_data;
        end
      end
      2'b01: begin
        h0_r <= h1_r;
      end
      2'b11: begin
        // head leaves: the older waiting entry (if any) moves up
        if (cnt_r == 2'd1) begin
          h0_r <= push_data;
        end else begin
          h0_r <= h1_r;
          h1_r <= push_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign full               = (cnt_r == 2'd2);
  assign out_chan.valid     = (cnt_r != 2'd0);
  assign out_chan.out0_re   = h0_r.out0_re;
  assign out_chan.out0_im   = h0_r.out0_im;
  assign out_chan.out1_re   = h0_r.out1_re;
  assign out_chan.out1_im   = h0_r.out1_im;
  assign out_chan.saturated = h0_r.saturated;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("result pushed into full output queue");
`endif

endmodule

[rtl/core/single_qubit_gate_apply_unit.sv]
// ----------------------------------------------------------------------------
// single_qubit_gate_apply_unit
// Applies Hadamard, phase, rotation or the fixed H/phase/rotation sequence
// to a two-amplitude Q1.14 qubit state, saturating the result.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  carries one state per transfer: mode, angle and four amplitudes.
//   out_chan returns one result per input, in order, with a clip flag.
//   Both channels transfer when valid and ready are high at a clock edge.
// Pipeline:
//   An item enters every cycle while the output queue is not full. Each
//   input passes 7 stages of sine/cosine (Horner chains, one multiply
//   per stage, then Q14 rounding), running beside the Hadamard stage,
//   followed by two-stage phase and rotation units and the saturation step.
//   Sustained throughput is one item per cycle while out_chan.ready is high.
// Reset (rst_n low, synchronous) empties the pipeline and the output queue;
//   no item is in flight afterwards.
// Stall: a two-entry queue holds finished results. While it is full the
//   whole pipeline holds its contents and in_chan.ready stays low; nothing
//   in flight is dropped or repeated. in_chan.ready does not depend on
//   out_chan.ready in the same cycle.
// ----------------------------------------------------------------------------
module single_qubit_gate_apply_unit import sqg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sqg_in_if.sink   in_chan,
  sqg_out_if.source out_chan
);

  logic       adv;
  logic       q_full;
  logic       push;
  out_item_t  push_data;

  logic [11:1] vld_r;
  gate_mode_t  mode_r [1:9];
  amp_set_t    dly_r  [3:7];
  trig_t       cs_r   [8:9];

  gate_mode_t in_mode;
  amp_set_t   in_amps;
  mix_coef_t  x_coef;
  amp_set_t   x_out;
  trig_t      trig_cs;
  trig_t      y_coef;
  amp_set_t   y_out;
  mix_coef_t  z_coef;
  amp_set_t   z_out;

  function automatic amp_t sat_amp(input wamp_t v);
    if (v > AMP_MAX) begin
      return AMP_MAX[AMP_WIDTH-1:0];
    end
    if (v < AMP_MIN) begin
      return AMP_MIN[AMP_WIDTH-1:0];
    end
    return v[AMP_WIDTH-1:0];
  endfunction

  function automatic logic clips(input wamp_t v);
    return (v > AMP_MAX) || (v < AMP_MIN);
  endfunction

  assign adv           = !q_full;
  assign in_chan.ready = adv;
  assign in_mode       = gate_mode_t'(in_chan.mode);

  assign in_amps.a0_re = WIDE_W'(in_chan.amp0_re);
  assign in_amps.a0_im = WIDE_W'(in_chan.amp0_im);
  assign in_amps.a1_re = WIDE_W'(in_chan.amp1_re);
  assign in_amps.a1_im = WIDE_W'(in_chan.amp1_im);

  // Gates not selected for a stage use the identity, which rounds exactly.
  always_comb begin
    unique case (in_mode)
      MODE_HAD, MODE_SEQ: x_coef = '{k00: INV_SQRT2, k01: INV_SQRT2,
                                     k10: INV_SQRT2, k11: -INV_SQRT2};
      default:            x_coef = '{k00: ONE_Q14, k01: ZERO_Q14,
                                     k10: ZERO_Q14, k11: ONE_Q14};
    endcase
  end

  always_comb begin
    unique case (mode_r[7])
      MODE_PHASE: y_coef = trig_cs;
      MODE_SEQ:   y_coef = '{c: COS_PI4, s: SIN_PI4};
      default:    y_coef = '{c: ONE_Q14, s: ZERO_Q14};
    endcase
  end

  always_comb begin
    unique case (mode_r[9])
      MODE_ROT: z_coef = '{k00: cs_r[9].c, k01: -cs_r[9].s,
                           k10: cs_r[9].s, k11: cs_r[9].c};
      MODE_SEQ: z_coef = '{k00: COS_PI6, k01: -SIN_PI6,
                           k10: SIN_PI6, k11: COS_PI6};
      default:  z_coef = '{k00: ONE_Q14, k01: ZERO_Q14,
                           k10: ZERO_Q14, k11: ONE_Q14};
    endcase
  end

  sqg_trig u_trig (
    .clk   (clk),
    .en    (adv),
    .angle (in_chan.angle),
    .cs    (trig_cs)
  );

  sqg_mix u_had (
    .clk (clk),
    .en  (adv),
    .a   (in_amps),
    .k   (x_coef),
    .y   (x_out)
  );

  sqg_phase u_phase (
    .clk (clk),
    .en  (adv),
    .a   (dly_r[7]),
    .cs  (y_coef),
    .y   (y_out)
  );

  sqg_mix u_rot (
    .clk (clk),
    .en  (adv),
    .a   (y_out),
    .k   (z_coef),
    .y   (z_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[10:1], in_chan.valid};
    end
  end

  // Align mode and amplitudes with the trig latency; delay the angle terms for the rotation unit.
  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r[1] <= in_mode;
      for (int k = 2; k <= 9; k++) begin
        mode_r[k] <= mode_r[k-1];
      end
      dly_r[3] <= x_out;
      for (int k = 4; k <= 7; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
      cs_r[8] <= trig_cs;
      cs_r[9] <= cs_r[8];
    end
  end

  always_comb begin
    push_data.out0_re   = sat_amp(z_out.a0_re);
    push_data.out0_im   = sat_amp(z_out.a0_im);
    push_data.out1_re   = sat_amp(z_out.a1_re);
    push_data.out1_im   = sat_amp(z_out.a1_im);
    push_data.saturated = clips(z_out.a0_re) || clips(z_out.a0_im) ||
                          clips(z_out.a1_re) || clips(z_out.a1_im);
  end

  assign push = adv && vld_r[11];

  sqg_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_chan  (out_chan)
  );

`ifndef ASSERT_OFF
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.saturated) |->
      (out_chan.out0_re == AMP_MAX[AMP_WIDTH-1:0] ||
       out_chan.out0_re == AMP_MIN[AMP_WIDTH-1:0] ||
       out_chan.out0_im == AMP_MAX[AMP_WIDTH-1:0] ||
       out_chan.out0_im == AMP_MIN[AMP_WIDTH-1:0] ||
       out_chan.out1_re == AMP_MAX[AMP_WIDTH-1:0] ||
       out_chan.out1_re == AMP_MIN[AMP_WIDTH-1:0] ||
       out_chan.out1_im == AMP_MAX[AMP_WIDTH-1:0] ||
       out_chan.out1_im == AMP_MIN[AMP_WIDTH-1:0]))
    else $error("clip flag set with no amplitude at a rail");
`endif
`ifndef ASSERT_OFF
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !adv) |=> $stable(vld_r))
    else $error("pipeline moved while output queue full");
`endif
`ifndef ASSERT_OFF
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[7] |-> (trig_cs.c <= ONE_Q14 && trig_cs.c >= -ONE_Q14 &&
                  trig_cs.s <= ONE_Q14 && trig_cs.s >= -ONE_Q14))
    else $error("sine or cosine outside unit range");
`endif

endmodule
